// ===== hdl/mtof_pkg.sv =====
// ----------------------------------------------------------------------------
// mtof_pkg
// Field widths, status codes and defaults for the median time offset filter.
// ----------------------------------------------------------------------------
package mtof_pkg;

    localparam int ADDR_W          = 32;
    localparam int TIME_W          = 34;
    localparam int OFS_W           = 35;
    localparam int ADJ_W           = 36;
    localparam int STAT_W          = 2;
    localparam int CNT_OUT_W       = 7;
    localparam int MIN_SAMPLES     = 5;
    localparam int DEF_MAX_SOURCES = 64;

    typedef logic signed [OFS_W-1:0] t_ofs;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== hdl/mtof_if.sv =====
// ----------------------------------------------------------------------------
// mtof_if
// Valid/ready channels for time reports in and filter results out.
// ----------------------------------------------------------------------------
interface mtof_in_if;
    import mtof_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_addr;
    logic [TIME_W-1:0] peer_time;
    logic [TIME_W-1:0] local_time;

    modport source (output valid, source_addr, peer_time, local_time, input ready);
    modport sink   (input valid, source_addr, peer_time, local_time, output ready);
endinterface

interface mtof_out_if;
    import mtof_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic                    median_updated;
    logic signed [OFS_W-1:0] current_offset;
    logic signed [ADJ_W-1:0] adjusted_time;
    logic [CNT_OUT_W-1:0]    sample_count;

    modport source (output valid, status, median_updated, current_offset, adjusted_time,
                    sample_count, input ready);
    modport sink   (input valid, status, median_updated, current_offset, adjusted_time,
                    sample_count, output ready);
endinterface

// ===== hdl/mtof_cmp.sv =====
// ----------------------------------------------------------------------------
// mtof_cmp
// Shared comparator: equality for the source scan, signed greater-than for
// the sorted insertion walk.
// ----------------------------------------------------------------------------
module mtof_cmp (
    input  mtof_pkg::t_ofs i_a,
    input  mtof_pkg::t_ofs i_b,
    output logic           o_eq,
    output logic           o_gt
);
    import mtof_pkg::*;

    assign o_eq = (i_a == i_b);
    assign o_gt = (i_a > i_b);

endmodule

// ===== hdl/median_time_offset_filter.sv =====
// ----------------------------------------------------------------------------
// median_time_offset_filter
// Running median clock offset over first reports from distinct sources.
//
//   channel  dir  handshake        payload
//   i_in     in   valid / ready    source_addr, peer_time, local_time
//   o_out    out  valid / ready    status, median_updated, current_offset,
//                                  adjusted_time, sample_count
//
// One beat at a time: the K known sources are scanned in the source RAM
// (one entry a cycle), then S entries are shifted in the sorted offset
// RAM (one a cycle, next entry read ahead).
// Reset clears the counts and the offset in force; the RAMs are not cleared.
// i_in.ready is low from accept until the result beat is taken on o_out.
// ----------------------------------------------------------------------------
module median_time_offset_filter #(
    parameter int MAX_SOURCES = mtof_pkg::DEF_MAX_SOURCES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtof_in_if.sink    i_in,
    mtof_out_if.source o_out
);
    import mtof_pkg::*;

    localparam int ST_DEPTH = MAX_SOURCES + 1;
    localparam int SIDX_W   = $clog2(MAX_SOURCES);
    localparam int KCNT_W   = $clog2(MAX_SOURCES + 1);
    localparam int STW      = $clog2(ST_DEPTH);
    localparam int CNT_W    = $clog2(ST_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_INS_RD, S_INS_CMP, S_INS_LAST,
        S_MED, S_MED_CAP, S_FIN, S_OUT
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_addr;
    logic [TIME_W-1:0]       r_local;
    t_ofs                    r_v;
    t_ofs                    r_ofs;
    logic signed [ADJ_W-1:0] r_adj;
    logic [STAT_W-1:0]       r_status;
    logic                    r_upd;
    logic [KCNT_W-1:0]       r_known_cnt;
    logic [CNT_W-1:0]        r_ocnt;
    logic [KCNT_W-1:0]       r_idx;
    logic                    r_rd_vld;
    logic [STW-1:0]          r_pos;

    logic [ADDR_W-1:0]       r_src_mem [MAX_SOURCES];
    logic [ADDR_W-1:0]       r_src_q;
    t_ofs                    r_st_mem [ST_DEPTH];
    t_ofs                    r_st_q;

    logic                    scan_issue;
    logic                    full;
    logic                    src_we;
    logic [SIDX_W-1:0]       src_raddr;
    logic                    st_we;
    logic [STW-1:0]          st_waddr;
    t_ofs                    st_wdata;
    logic [STW-1:0]          st_raddr;
    logic [CNT_W-1:0]        half_cnt;
    logic                    med_go;
    t_ofs                    cmp_a;
    t_ofs                    cmp_b;
    logic                    cmp_eq;
    logic                    cmp_gt;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
    logic [CNT_W-1:0]        known_p1;

    mtof_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_eq (cmp_eq),
        .o_gt (cmp_gt)
    );

    assign scan_issue = (r_state == S_SCAN) && (r_idx < r_known_cnt);
    assign full       = (r_known_cnt == KCNT_W'(MAX_SOURCES));
    assign half_cnt   = r_ocnt >> 1;
    assign med_go     = (r_ocnt >= CNT_W'(MIN_SAMPLES)) && r_ocnt[0];
    assign src_we     = (r_state == S_CHECK) && !full;
    assign src_raddr  = scan_issue ? r_idx[SIDX_W-1:0] : '0;

    assign cmp_a = (r_state == S_SCAN) ? t_ofs'({{(OFS_W-ADDR_W){1'b0}}, r_src_q}) : r_st_q;
    assign cmp_b = (r_state == S_SCAN) ? t_ofs'({{(OFS_W-ADDR_W){1'b0}}, r_addr}) : r_v;

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_pos;
        st_wdata = r_v;
        st_raddr = '0;
        case (r_state)
            S_CHECK: begin
                if (!full && r_ocnt == '0) begin
                    st_we    = 1'b1;
                    st_waddr = '0;
                    st_wdata = '0;
                end
            end
            S_INS_RD: begin
                st_raddr = r_pos - STW'(1);
            end
            S_INS_CMP: begin
                st_we = 1'b1;
                if (cmp_gt) begin
                    st_wdata = r_st_q;
                    if (r_pos > STW'(1)) begin
                        st_raddr = r_pos - STW'(2);
                    end
                end
            end
            S_INS_LAST: begin
                st_we    = 1'b1;
                st_waddr = '0;
            end
            S_MED: begin
                st_raddr = half_cnt[STW-1:0];
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            r_src_mem[r_known_cnt[SIDX_W-1:0]] <= r_addr;
        end
        r_src_q <= r_src_mem[src_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        r_st_q <= r_st_mem[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_known_cnt <= '0;
            r_ocnt      <= '0;
            r_ofs       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_addr   <= i_in.source_addr;
                        r_local  <= i_in.local_time;
                        r_v      <= t_ofs'($signed({1'b0, i_in.peer_time}))
                                  - t_ofs'($signed({1'b0, i_in.local_time}));
                        r_upd    <= 1'b0;
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= scan_issue;
                    if (scan_issue) begin
                        r_idx <= r_idx + KCNT_W'(1);
                    end
                    if (r_rd_vld && cmp_eq) begin
                        r_status <= ST_DUP;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_FIN;
                    end else if (!scan_issue && !r_rd_vld) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (full) begin
                        r_status <= ST_FULL;
                        r_state  <= S_FIN;
                    end else begin
                        r_status    <= ST_OK;
                        r_known_cnt <= r_known_cnt + KCNT_W'(1);
                        if (r_ocnt == '0) begin
                            r_ocnt <= CNT_W'(1);
                            r_pos  <= STW'(1);
                        end else begin
                            r_pos <= r_ocnt[STW-1:0];
                        end
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    if (cmp_gt) begin
                        r_pos <= r_pos - STW'(1);
                        if (r_pos == STW'(1)) begin
                            r_state <= S_INS_LAST;
                        end
                    end else begin
                        r_ocnt  <= r_ocnt + CNT_W'(1);
                        r_state <= S_MED;
                    end
                end
                S_INS_LAST: begin
                    r_ocnt  <= r_ocnt + CNT_W'(1);
                    r_state <= S_MED;
                end
                S_MED: begin
                    r_state <= med_go ? S_MED_CAP : S_FIN;
                end
                S_MED_CAP: begin
                    r_ofs   <= r_st_q;
                    r_upd   <= 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_adj   <= ADJ_W'($signed({1'b0, r_local})) + ADJ_W'(r_ofs);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign cnt_ext  = {{CNT_OUT_W{1'b0}}, r_ocnt};
    assign known_p1 = CNT_W'(r_known_cnt) + CNT_W'(1);

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.status         = r_status;
    assign o_out.median_updated = r_upd;
    assign o_out.current_offset = r_ofs;
    assign o_out.adjusted_time  = r_adj;
    assign o_out.sample_count   = cnt_ext[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            ((r_known_cnt == '0 && r_ocnt == '0) || (r_ocnt == known_p1)))
        else $error("offset count out of step with source count");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    a_upd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.median_updated) |-> (o_out.status == ST_OK))
        else $error("median update on rejected beat");

    a_known_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known_cnt <= KCNT_W'(MAX_SOURCES))
        else $error("source count overflow");
`endif

endmodule

// ===== verif/tb_median_time_offset_filter.sv =====
// ----------------------------------------------------------------------------
// tb_median_time_offset_filter
// Self-checking bench for the running median clock offset filter.
//
// Time reports go in on a valid/ready channel. A behavioral model of the
// source table and the sorted offset store predicts the status, the offset
// in force, the adjusted time and the sample count for every accepted beat.
// Each result beat is checked field by field against the oldest prediction.
// Coverage comes from directed extremes, a receiver hold-off that backs up
// the input, and random reports before and after the source table fills.
// Both sides idle in random bursts, except in a quiet stretch at the end.
// ----------------------------------------------------------------------------
module tb_median_time_offset_filter;
    import mtof_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                SRC_CAP        = DEF_MAX_SOURCES;
    localparam int                ITEMS_TARGET   = 1650;
    localparam int                QUIET_TAIL     = 200;
    localparam int                RX_HOLD_CYCLES = 400;
    localparam int                SETTLE_CYCLES  = 2 * SRC_CAP + 40;
    localparam logic [TIME_W-1:0] T_MAX          = '1;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic                    updated;
        t_ofs                    offset;
        logic signed [ADJ_W-1:0] adjusted;
        logic [CNT_OUT_W-1:0]    count;
    } t_filter_result;

    logic i_clk;
    logic i_rst_n;

    mtof_in_if  in_ch ();
    mtof_out_if out_ch ();

    median_time_offset_filter #(
        .MAX_SOURCES(SRC_CAP)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // model state
    logic [ADDR_W-1:0] known_addr [SRC_CAP];
    int                known_cnt;
    t_ofs              sorted_ofs [SRC_CAP+1];
    int                ofs_cnt;
    t_ofs              ofs_in_force;

    t_filter_result    pending_reports[$];
    int                mismatch_count;
    int                result_index;
    int                items_sent;
    bit                idle_on;
    bit                hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit is_known(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < known_cnt; i++) begin
            if (known_addr[i] == addr) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [ADDR_W-1:0] fresh_addr();
        logic [ADDR_W-1:0] a;
        a = $urandom();
        while (is_known(a)) a = $urandom();
        return a;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TIME_W-1:0];
    endfunction

    task automatic pick_times(output logic [TIME_W-1:0] peer, output logic [TIME_W-1:0] loc);
        logic [TIME_W-1:0] delta;
        loc   = rand_time();
        peer  = rand_time();
        delta = $urandom_range(0, 1000);
        case ($urandom_range(0, 5))
            0, 1: ;
            2, 3: begin
                if ($urandom_range(0, 1) == 1)
                    peer = (loc > T_MAX - delta) ? T_MAX : loc + delta;
                else
                    peer = (loc < delta) ? '0 : loc - delta;
            end
            4: peer = ($urandom_range(0, 1) == 1) ? T_MAX : '0;
            default: loc = ($urandom_range(0, 1) == 1) ? T_MAX : '0;
        endcase
    endtask

    task automatic predict_report(input logic [ADDR_W-1:0] addr,
                                  input logic [TIME_W-1:0] peer,
                                  input logic [TIME_W-1:0] loc);
        t_filter_result r;
        t_ofs           d;
        int             pos;
        r.updated = 1'b0;
        if (is_known(addr)) begin
            r.status = ST_DUP;
        end else if (known_cnt >= SRC_CAP) begin
            r.status = ST_FULL;
        end else begin
            r.status = ST_OK;
            known_addr[known_cnt] = addr;
            known_cnt++;
            if (ofs_cnt == 0) begin
                sorted_ofs[0] = '0;
                ofs_cnt = 1;
            end
            d   = $signed({1'b0, peer}) - $signed({1'b0, loc});
            pos = ofs_cnt;
            while (pos > 0 && sorted_ofs[pos-1] > d) begin
                sorted_ofs[pos] = sorted_ofs[pos-1];
                pos--;
            end
            sorted_ofs[pos] = d;
            ofs_cnt++;
            if (ofs_cnt >= MIN_SAMPLES && (ofs_cnt % 2) == 1) begin
                ofs_in_force = sorted_ofs[ofs_cnt / 2];
                r.updated    = 1'b1;
            end
        end
        r.offset   = ofs_in_force;
        r.adjusted = $signed({2'b00, loc}) + ofs_in_force;
        r.count    = ofs_cnt[CNT_OUT_W-1:0];
        pending_reports = {pending_reports, r};
    endtask

    task automatic send_report(input logic [ADDR_W-1:0] addr,
                               input logic [TIME_W-1:0] peer,
                               input logic [TIME_W-1:0] loc);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.source_addr <= addr;
        in_ch.peer_time   <= peer;
        in_ch.local_time  <= loc;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_report(addr, peer, loc);
    endtask

    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s on result %0d, got %0h, want %0h", what, result_index, got, want);
        mismatch_count++;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        t_filter_result e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected beat", out_ch.status, '0);
                end else begin
                    e = pending_reports.pop_front();
                    if (out_ch.status !== e.status)
                        report_mismatch("status", out_ch.status, e.status);
                    if (out_ch.median_updated !== e.updated)
                        report_mismatch("median_updated", out_ch.median_updated, e.updated);
                    if (out_ch.current_offset !== e.offset)
                        report_mismatch("current_offset", out_ch.current_offset, e.offset);
                    if (out_ch.adjusted_time !== e.adjusted)
                        report_mismatch("adjusted_time", out_ch.adjusted_time, e.adjusted);
                    if (out_ch.sample_count !== e.count)
                        report_mismatch("sample_count", out_ch.sample_count, e.count);
                end
                result_index++;
            end
        end
    end

    task automatic test_directed_extremes();
        send_report(32'h0000_0000, '0, '0);
        send_report(32'hFFFF_FFFF, T_MAX, '0);
        send_report(32'h0000_0001, '0, T_MAX);
        send_report(32'h0000_0002, T_MAX, T_MAX);
        send_report(32'h0000_0000, T_MAX, 34'h1);
        for (int i = 0; i < 4; i++) send_report(32'hAAAA_AAA0 + i, T_MAX, '0);
        send_report(32'hFFFF_FFFF, '0, T_MAX);
        send_report(32'h0000_0001, '0, '0);
        for (int i = 0; i < 8; i++) send_report(32'h5555_5550 + i, '0, T_MAX);
        send_report(32'h0000_0002, T_MAX, '0);
    endtask

    task automatic test_backpressure();
        logic [TIME_W-1:0] peer;
        logic [TIME_W-1:0] loc;
        hold_req = 1'b1;
        for (int i = 0; i < 5; i++) begin
            pick_times(peer, loc);
            send_report(fresh_addr(), peer, loc);
        end
        drain_reports();
    endtask

    task automatic test_random_fill();
        logic [TIME_W-1:0] peer;
        logic [TIME_W-1:0] loc;
        while (known_cnt < SRC_CAP) begin
            pick_times(peer, loc);
            if ($urandom_range(0, 3) == 0)
                send_report(known_addr[$urandom_range(0, known_cnt - 1)], peer, loc);
            else
                send_report(fresh_addr(), peer, loc);
        end
    endtask

    task automatic test_full_table();
        send_report(fresh_addr(), T_MAX, '0);
        send_report(known_addr[0], '0, T_MAX);
        send_report(known_addr[SRC_CAP-1], T_MAX, T_MAX);
        send_report(fresh_addr(), '0, '0);
    endtask

    task automatic test_random_rejects(input int item_limit);
        logic [TIME_W-1:0] peer;
        logic [TIME_W-1:0] loc;
        while (items_sent < item_limit) begin
            pick_times(peer, loc);
            if ($urandom_range(0, 2) == 0)
                send_report(known_addr[$urandom_range(0, SRC_CAP - 1)], peer, loc);
            else
                send_report(fresh_addr(), peer, loc);
        end
    endtask

    initial begin
        known_cnt      = 0;
        ofs_cnt        = 0;
        ofs_in_force   = '0;
        mismatch_count = 0;
        result_index   = 0;
        items_sent     = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.source_addr <= '0;
        in_ch.peer_time   <= '0;
        in_ch.local_time  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_backpressure();
        test_random_fill();
        test_full_table();
        test_random_rejects(ITEMS_TARGET - QUIET_TAIL);
        idle_on = 1'b0;
        test_random_rejects(ITEMS_TARGET);

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
